### hdl/ptt_pkg.sv
// Shared types and constants of the periodic timer table.
package ptt_pkg;

  // Fixed field widths.
  localparam int TIME_W       = 40;
  localparam int PERIOD_W     = 32;
  localparam int DELAY_W      = 32;
  localparam int OWNER_PORT_W = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_SLOTS      = 16;
  localparam int DEF_OWNER_BITS = 8;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  // Result kinds.
  typedef enum logic [2:0] {
    K_EXPIRY     = 3'd0,
    K_REGISTERED = 3'd1,
    K_DUPLICATE  = 3'd2,
    K_FULL       = 3'd3,
    K_REMOVED    = 3'd4,
    K_NOT_FOUND  = 3'd5
  } kind_t;

  // One registered result, with its strobe.
  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic [OWNER_PORT_W-1:0] owner;
    logic                    last;
  } result_t;

endpackage

### hdl/ptt_mem.sv
// Entry memory of the timer table: one write port, one registered read port.
module ptt_mem import ptt_pkg::*; #(
  parameter int DEPTH  = DEF_SLOTS,
  parameter int WIDTH  = DEF_OWNER_BITS + TIME_W + PERIOD_W,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/ptt_engine.sv
// Sequencer of the timer table: walks the entry memory, compacts it and builds results.
module ptt_engine import ptt_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int OWNER_BITS = DEF_OWNER_BITS,
  parameter int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int ENTRY_W    = OWNER_BITS + TIME_W + PERIOD_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode,
  input  logic [OWNER_PORT_W-1:0] owner_id,
  input  logic [DELAY_W-1:0]      delay_ms,
  input  logic [PERIOD_W-1:0]     period_ms,
  output logic                    mem_we,
  output logic [IDX_W-1:0]        mem_waddr,
  output logic [ENTRY_W-1:0]      mem_wdata,
  output logic [IDX_W-1:0]        mem_raddr,
  input  logic [ENTRY_W-1:0]      mem_rdata,
  output result_t                 res
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int KEY_W = (OWNER_BITS < OWNER_PORT_W) ? OWNER_BITS : OWNER_PORT_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                  state;
  opcode_t                 op;
  logic [OWNER_BITS-1:0]   key;
  logic [DELAY_W-1:0]      delay;
  logic [PERIOD_W-1:0]     period_in;
  logic [TIME_W-1:0]       now;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        ridx;
  logic [CNT_W-1:0]        widx;
  logic                    found;
  logic                    pend_valid;
  logic [OWNER_BITS-1:0]   pend_owner;
  result_t                 res_next;

  logic [OWNER_BITS-1:0]   e_owner;
  logic [TIME_W-1:0]       e_deadline;
  logic [PERIOD_W-1:0]     e_period;
  logic [TIME_W-1:0]       dl_next;
  logic [TIME_W-1:0]       new_deadline;
  logic [CNT_W-1:0]        ridx_ext;
  logic                    hit;
  logic                    one_shot;
  logic                    own_match;
  logic                    more;
  logic                    full;

  assign busy = (state != S_IDLE);

  // Fields of the entry read in the previous cycle.
  assign e_owner    = mem_rdata[ENTRY_W-1 -: OWNER_BITS];
  assign e_deadline = mem_rdata[PERIOD_W +: TIME_W];
  assign e_period   = mem_rdata[PERIOD_W-1:0];

  // Expiry check and reload of the current entry.
  assign hit          = (e_deadline <= now);
  assign one_shot     = (e_period == '0);
  assign dl_next      = e_deadline + TIME_W'(e_period);
  assign own_match    = (e_owner == key);
  assign new_deadline = now + TIME_W'(delay);
  assign full         = (count == CNT_W'(SLOTS));

  // The walk continues while another live entry lies beyond the current one.
  assign ridx_ext = CNT_W'(ridx);
  assign more     = ((ridx_ext + CNT_W'(1)) < count);

  // Memory port: read ahead by one entry, write kept entries back compacted.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = widx[IDX_W-1:0];
    mem_wdata = {e_owner, ((op == OP_TICK) && hit) ? dl_next : e_deadline, e_period};
    mem_raddr = (state == S_IDLE) ? '0 : IDX_W'(ridx_ext + CNT_W'(1));
    unique case (state)
      S_WALK: begin
        if (op == OP_TICK) begin
          mem_we = !(hit && one_shot);
        end else if (op == OP_REMOVE) begin
          mem_we = !(own_match && !found);
        end
      end
      S_FINISH: begin
        if ((op == OP_REGISTER) && !found && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count[IDX_W-1:0];
          mem_wdata = {key, new_deadline, period_in};
        end
      end
      default: begin
      end
    endcase
  end

  // Next result: an expiry is held back until the next one or the end of
  // the walk shows whether it is the last.
  always_comb begin
    res_next = '0;
    unique case (state)
      S_WALK: begin
        if ((op == OP_TICK) && hit && pend_valid) begin
          res_next = '{valid: 1'b1, kind: K_EXPIRY,
                       owner: OWNER_PORT_W'(pend_owner), last: 1'b0};
        end
      end
      S_FINISH: begin
        unique case (op)
          OP_TICK: begin
            if (pend_valid) begin
              res_next = '{valid: 1'b1, kind: K_EXPIRY,
                           owner: OWNER_PORT_W'(pend_owner), last: 1'b1};
            end
          end
          OP_REGISTER: begin
            if (found) begin
              res_next = '{valid: 1'b1, kind: K_DUPLICATE,
                           owner: OWNER_PORT_W'(key), last: 1'b1};
            end else if (full) begin
              res_next = '{valid: 1'b1, kind: K_FULL,
                           owner: OWNER_PORT_W'(key), last: 1'b1};
            end else begin
              res_next = '{valid: 1'b1, kind: K_REGISTERED,
                           owner: OWNER_PORT_W'(key), last: 1'b1};
            end
          end
          OP_REMOVE: begin
            res_next = '{valid: 1'b1, kind: found ? K_REMOVED : K_NOT_FOUND,
                         owner: OWNER_PORT_W'(key), last: 1'b1};
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now        <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      res        <= '0;
    end else begin
      res <= res_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op         <= opcode_t'(opcode);
            key        <= OWNER_BITS'(owner_id[KEY_W-1:0]);
            delay      <= delay_ms;
            period_in  <= period_ms;
            ridx       <= '0;
            widx       <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            if (opcode_t'(opcode) != OP_UNUSED) begin
              if (opcode_t'(opcode) == OP_TICK) begin
                now <= now + TIME_W'(1);
              end
              state <= (count == '0) ? S_FINISH : S_WALK;
            end
          end
        end
        S_WALK: begin
          // One entry per cycle; a hit becomes the held expiry.
          if (op == OP_TICK) begin
            if (hit) begin
              pend_valid <= 1'b1;
              pend_owner <= e_owner;
            end
            if (!(hit && one_shot)) begin
              widx <= widx + CNT_W'(1);
            end
          end else if (op == OP_REMOVE) begin
            if (own_match && !found) begin
              found <= 1'b1;
            end else begin
              widx <= widx + CNT_W'(1);
            end
          end else if (own_match) begin
            found <= 1'b1;
          end
          if (more) begin
            ridx <= ridx + IDX_W'(1);
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_IDLE;
          unique case (op)
            OP_TICK: begin
              count <= widx;
            end
            OP_REGISTER: begin
              if (!found && !full) begin
                count <= count + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              count <= widx;
            end
            default: begin
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/periodic_timer_table.sv
// Top level of the periodic timer table.
//
//   Channel   Handshake            Signals
//   request   start, busy          opcode, owner_id, delay_ms, period_ms
//   result    strobe (no stall)    kind, owner_id_res, last
//
// A request is taken when start is high and busy is low. Tick, register and
// remove requests walk the live entries of the entry memory, one entry per
// cycle through its single read port, then pass a closing state before the
// next request can be taken; an empty table skips the walk, and an unused
// opcode leaves the block idle.
// An expiry is held back until the next expiry or the end of the walk shows
// whether it is the last; the last result of a request appears in the first
// cycle in which busy is low again, and each result lasts one cycle.
// Reset is synchronous and clears the clock and the entry count; the entry
// memory needs no clearing. The result side cannot stall the block.
module periodic_timer_table import ptt_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int OWNER_BITS = DEF_OWNER_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode,
  input  logic [OWNER_PORT_W-1:0] owner_id,
  input  logic [DELAY_W-1:0]      delay_ms,
  input  logic [PERIOD_W-1:0]     period_ms,
  output logic                    strobe,
  output logic [2:0]              kind,
  output logic [OWNER_PORT_W-1:0] owner_id_res,
  output logic                    last
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = OWNER_BITS + TIME_W + PERIOD_W;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  result_t            res;

  // Sequencer.
  ptt_engine #(
    .SLOTS      (SLOTS),
    .OWNER_BITS (OWNER_BITS),
    .IDX_W      (IDX_W),
    .ENTRY_W    (ENTRY_W)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .owner_id  (owner_id),
    .delay_ms  (delay_ms),
    .period_ms (period_ms),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res       (res)
  );

  // Entry memory.
  ptt_mem #(
    .DEPTH  (SLOTS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result ports.
  assign strobe       = res.valid;
  assign kind         = res.kind;
  assign owner_id_res = res.owner;
  assign last         = res.last;

  // The memory is written only while a request is being worked on.
  assert property (@(posedge clk) disable iff (rst) mem_we |-> busy)
    else $error("entry memory written while idle");

  // Writes stay inside the table.
  assert property (@(posedge clk) disable iff (rst) mem_we |-> (mem_waddr < SLOTS))
    else $error("entry memory write beyond the table");

  // Every valid request except the unused code makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode != OP_UNUSED)) |=> busy)
    else $error("request taken without starting work");

  // A result only comes out of work that was in progress.
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result without a request in progress");

endmodule

### sim/periodic_timer_table_test.sv
// Self-checking testbench for the periodic timer table, with a built-in table predictor.
module periodic_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  localparam int SLOTS      = DEF_SLOTS;
  localparam int OWNER_BITS = DEF_OWNER_BITS;
  localparam logic [OWNER_PORT_W-1:0] OWNER_MASK = OWNER_PORT_W'((1 << OWNER_BITS) - 1);
  // A request walks at most SLOTS entries; allow for gaps and many walks in a row.
  localparam int IDLE_LIMIT  = 25 * (SLOTS + 6);
  localparam int SETTLE_WAIT = 2 * SLOTS + 10;

  typedef struct packed {
    kind_t                   kind;
    logic [OWNER_PORT_W-1:0] owner;
    logic                    last;
  } timer_event_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              opcode;
  logic [OWNER_PORT_W-1:0] owner_id;
  logic [DELAY_W-1:0]      delay_ms;
  logic [PERIOD_W-1:0]     period_ms;
  logic                    strobe;
  logic [2:0]              kind;
  logic [OWNER_PORT_W-1:0] owner_id_res;
  logic                    last;

  // Predicted state of the timer table.
  logic [TIME_W-1:0]       clock_ms;
  int                      live_count;
  logic [OWNER_PORT_W-1:0] timer_owner [SLOTS];
  logic [TIME_W-1:0]       timer_deadline [SLOTS];
  logic [PERIOD_W-1:0]     timer_period [SLOTS];

  timer_event_t pending_events[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           steady_sender;

  periodic_timer_table #(
    .SLOTS     (SLOTS),
    .OWNER_BITS(OWNER_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .owner_id    (owner_id),
    .delay_ms    (delay_ms),
    .period_ms   (period_ms),
    .strobe      (strobe),
    .kind        (kind),
    .owner_id_res(owner_id_res),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Table predictor: position of an owner, or SLOTS when absent.
  function automatic int find_timer(logic [OWNER_PORT_W-1:0] owner);
    for (int i = 0; i < live_count; i++) begin
      if (timer_owner[i] == owner) return i;
    end
    return SLOTS;
  endfunction

  // Delete one entry and close the gap behind it.
  function automatic void drop_timer(int slot);
    for (int i = slot; i + 1 < live_count; i++) begin
      timer_owner[i]    = timer_owner[i + 1];
      timer_deadline[i] = timer_deadline[i + 1];
      timer_period[i]   = timer_period[i + 1];
    end
    live_count--;
  endfunction

  function automatic void push_event(kind_t k, logic [OWNER_PORT_W-1:0] owner, logic is_last);
    timer_event_t ev;
    ev.kind  = k;
    ev.owner = owner;
    ev.last  = is_last;
    pending_events.insert(pending_events.size(), ev);
  endfunction

  // Apply one accepted request to the predicted table and queue its results.
  function automatic void predict_timer_events(opcode_t op, logic [OWNER_PORT_W-1:0] owner_in,
                                               logic [DELAY_W-1:0] delay,
                                               logic [PERIOD_W-1:0] period);
    logic [OWNER_PORT_W-1:0] owner;
    int slot;
    int fired;
    owner = owner_in & OWNER_MASK;
    case (op)
      OP_REGISTER: begin
        if (find_timer(owner) < SLOTS) begin
          push_event(K_DUPLICATE, owner, 1'b1);
        end else if (live_count >= SLOTS) begin
          push_event(K_FULL, owner, 1'b1);
        end else begin
          timer_owner[live_count]    = owner;
          timer_deadline[live_count] = clock_ms + TIME_W'(delay);
          timer_period[live_count]   = period;
          live_count++;
          push_event(K_REGISTERED, owner, 1'b1);
        end
      end
      OP_REMOVE: begin
        slot = find_timer(owner);
        if (slot < SLOTS) begin
          drop_timer(slot);
          push_event(K_REMOVED, owner, 1'b1);
        end else begin
          push_event(K_NOT_FOUND, owner, 1'b1);
        end
      end
      OP_TICK: begin
        clock_ms = clock_ms + TIME_W'(1);
        slot = 0;
        fired = 0;
        // A periodic entry fires at most once per tick; a one-shot entry is freed.
        while (slot < live_count) begin
          if (timer_deadline[slot] <= clock_ms) begin
            push_event(K_EXPIRY, timer_owner[slot], 1'b0);
            fired++;
            if (timer_period[slot] != '0) begin
              timer_deadline[slot] = timer_deadline[slot] + TIME_W'(timer_period[slot]);
              slot++;
            end else begin
              drop_timer(slot);
            end
          end else begin
            slot++;
          end
        end
        if (fired > 0) pending_events[pending_events.size() - 1].last = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // Send one request after a random gap (none in steady mode); start is left high for a back-to-back request.
  task automatic send_request(opcode_t op, logic [OWNER_PORT_W-1:0] owner,
                              logic [DELAY_W-1:0] delay, logic [PERIOD_W-1:0] period);
    int gap;
    gap = steady_sender ? 0 : $urandom_range(0, 4);
    if (gap > 0 && start) begin
      @(negedge clk);
      start <= 1'b0;
      gap--;
    end
    repeat (gap) @(negedge clk);
    @(negedge clk);
    start     <= 1'b1;
    opcode    <= op;
    owner_id  <= owner;
    delay_ms  <= delay;
    period_ms <= period;
    do @(posedge clk); while (busy);
    predict_timer_events(op, owner, delay, period);
  endtask

  task automatic release_request();
    if (start) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Hold the sender until every predicted result has been seen.
  task automatic wait_for_results();
    release_request();
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Empty-table behavior: quiet tick, unknown owner, unused opcode.
  task automatic test_quiet_requests();
    send_request(OP_TICK, 8'h00, '0, '0);
    send_request(OP_REMOVE, 8'h00, '0, '0);
    send_request(OP_UNUSED, 8'hFF, '1, '1);
    send_request(OP_REMOVE, 8'hFF, '1, '1);
  endtask

  // One-shot, periodic, duplicate, late periodic and field extremes.
  task automatic test_one_shot_and_periodic();
    send_request(OP_REGISTER, 8'h00, 32'd0, 32'd0);
    send_request(OP_REGISTER, 8'hFF, 32'd1, 32'd1);
    send_request(OP_REGISTER, 8'hFF, 32'd5, 32'd0);
    send_request(OP_TICK, 8'h00, '0, '0);
    send_request(OP_TICK, 8'h00, '0, '0);
    send_request(OP_REGISTER, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Deadline now with period 1: the reload lands on the new time itself.
    send_request(OP_REGISTER, 8'h55, 32'd0, 32'd1);
    send_request(OP_TICK, 8'h00, '0, '0);
    send_request(OP_TICK, 8'h00, '0, '0);
    send_request(OP_REMOVE, 8'hFF, '0, '0);
    send_request(OP_REMOVE, 8'hAA, '0, '0);
    send_request(OP_REMOVE, 8'h55, '0, '0);
    send_request(OP_REMOVE, 8'h55, '0, '0);
  endtask

  // Fill the table, overflow it, and let all entries fire in a single tick.
  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++) begin
      send_request(OP_REGISTER, 8'(4 + i), 32'd3, (i % 2 == 1) ? 32'd2 : 32'd0);
    end
    send_request(OP_REGISTER, 8'hC3, 32'd1, 32'd1);
    send_request(OP_REGISTER, 8'd4, 32'd1, 32'd1);
    repeat (3) send_request(OP_TICK, 8'h00, '0, '0);
  endtask

  // Random mix over a small owner pool, so that duplicates, removals and a full table occur.
  task automatic test_random_traffic(int request_total);
    int sent;
    int pick;
    opcode_t op;
    logic [OWNER_PORT_W-1:0] owner;
    logic [DELAY_W-1:0] delay;
    logic [PERIOD_W-1:0] period;
    sent = 0;
    while (sent < request_total) begin
      if (sent % 25 == 0) steady_sender = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = OP_TICK;
      else if (pick < 75) op = OP_REGISTER;
      else if (pick < 94) op = OP_REMOVE;
      else                op = OP_UNUSED;
      owner = ($urandom_range(0, 4) == 0) ? OWNER_PORT_W'($urandom_range(0, 255))
                                          : OWNER_PORT_W'($urandom_range(0, 19));
      pick = $urandom_range(0, 99);
      if (pick < 60)      delay = $urandom_range(0, 8);
      else if (pick < 85) delay = $urandom_range(0, 60);
      else                delay = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 35)      period = '0;
      else if (pick < 80) period = $urandom_range(1, 12);
      else                period = $urandom();
      send_request(op, owner, delay, period);
      if (op != OP_UNUSED) sent++;
      if (sent == request_total / 2 && op != OP_UNUSED) wait_for_results();
    end
    steady_sender = 1'b0;
  endtask

  // Compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    timer_event_t seen;
    timer_event_t want;
    if (!rst && strobe) begin
      seen.kind  = kind_t'(kind);
      seen.owner = owner_id_res;
      seen.last  = last;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result kind=%0d owner=%0d last=%0b",
                 $time, kind, owner_id_res, last);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (seen !== want) begin
          $display("%0t: expected kind=%0d owner=%0d last=%0b, got kind=%0d owner=%0d last=%0b",
                   $time, want.kind, want.owner, want.last, kind, owner_id_res, last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither a request nor a result is taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    opcode        = OP_TICK;
    owner_id      = '0;
    delay_ms      = '0;
    period_ms     = '0;
    clock_ms      = '0;
    live_count    = 0;
    steady_sender = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_quiet_requests();
    test_one_shot_and_periodic();
    wait_for_results();
    test_full_table();
    test_random_traffic(150);

    // Drain, then leave room for any stray late result.
    wait_for_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0 && pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
